/* sv/aarm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aarm_pkg: shared types and constants for the axis-angle rotation matrix
// Fixed-point constants, pipeline depths and inter-module payload structs.
// ----------------------------------------------------------------------------
package aarm_pkg;

    localparam logic [30:0] Q30_ONE    = 31'h4000_0000;
    localparam logic [63:0] TWO_PI_Q44 = 64'h0000_6487_ED51_10B4;

    // Taylor divisors, step 0 is the k = 9 term
    localparam int unsigned SIN_DIV [9] = '{342, 272, 210, 156, 110, 72, 42, 20, 6};
    localparam int unsigned COS_DIV [9] = '{306, 240, 182, 132, 90, 56, 30, 12, 2};

    localparam int unsigned NORM_LAT = 67;
    localparam int unsigned SC_LAT   = 38;
    localparam int unsigned MAT_LAT  = 3;
    localparam int unsigned TOT_LAT  = NORM_LAT + MAT_LAT;
    localparam int unsigned TRIG_DLY = NORM_LAT - SC_LAT;

    typedef struct packed {
        logic signed [31:0] u_x;
        logic signed [31:0] u_y;
        logic signed [31:0] u_z;
        logic               zero;
    } t_unit;

    typedef struct packed {
        logic signed [31:0] sn;
        logic signed [31:0] cs;
    } t_trig;

endpackage
`default_nettype wire

/* sv/axis_angle_rotation_matrix.sv */
// Throughput: one beat per cycle; the single pipeline enable stalls all
// stages together while an output beat is held by i_out_stall.
// Depth is set by the 32-stage square root and 31-stage divider in the
// axis path. Synchronous active-low reset clears the stage valid bits only.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix: pipelined Rodrigues rotation matrix
// Normalizes the axis, forms sine and cosine of the angle, and outputs the
// nine 3x3 matrix elements in signed Q1.OUT_FRAC_BITS.
// ----------------------------------------------------------------------------
module axis_angle_rotation_matrix import aarm_pkg::*; #(
    parameter int unsigned OUT_FRAC_BITS = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic signed [31:0]              i_axis_x,
    input  wire logic signed [31:0]              i_axis_y,
    input  wire logic signed [31:0]              i_axis_z,
    input  wire logic signed [31:0]              i_angle,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic signed [OUT_FRAC_BITS+1:0]      o_elem_r0c0,
    output logic signed [OUT_FRAC_BITS+1:0]      o_elem_r0c1,
    output logic signed [OUT_FRAC_BITS+1:0]      o_elem_r0c2,
    output logic signed [OUT_FRAC_BITS+1:0]      o_elem_r1c0,
    output logic signed [OUT_FRAC_BITS+1:0]      o_elem_r1c1,
    output logic signed [OUT_FRAC_BITS+1:0]      o_elem_r1c2,
    output logic signed [OUT_FRAC_BITS+1:0]      o_elem_r2c0,
    output logic signed [OUT_FRAC_BITS+1:0]      o_elem_r2c1,
    output logic signed [OUT_FRAC_BITS+1:0]      o_elem_r2c2,
    output logic                                 o_zero_axis
);

    logic                          en;
    logic [TOT_LAT-1:0]            r_vld;
    t_unit                         w_unit;
    t_trig                         w_trig;
    t_trig                         r_dly [TRIG_DLY];
    logic signed [OUT_FRAC_BITS+1:0] w_elem [9];

    assign en         = ~(r_vld[TOT_LAT-1] & i_out_stall);
    assign o_in_stall = ~en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[TOT_LAT-2:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dly[0] <= w_trig;
            for (int i = 1; i < TRIG_DLY; i++) begin
                r_dly[i] <= r_dly[i-1];
            end
        end
    end

    aarm_norm u_norm (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_axis_x (i_axis_x),
        .i_axis_y (i_axis_y),
        .i_axis_z (i_axis_z),
        .o_unit   (w_unit)
    );

    aarm_sincos u_sincos (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (i_angle),
        .o_trig  (w_trig)
    );

    aarm_matrix #(
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_matrix (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_unit (w_unit),
        .i_trig (r_dly[TRIG_DLY-1]),
        .o_elem (w_elem),
        .o_zero (o_zero_axis)
    );

    assign o_out_valid = r_vld[TOT_LAT-1];
    assign o_elem_r0c0 = w_elem[0];
    assign o_elem_r0c1 = w_elem[1];
    assign o_elem_r0c2 = w_elem[2];
    assign o_elem_r1c0 = w_elem[3];
    assign o_elem_r1c1 = w_elem[4];
    assign o_elem_r1c2 = w_elem[5];
    assign o_elem_r2c0 = w_elem[6];
    assign o_elem_r2c1 = w_elem[7];
    assign o_elem_r2c2 = w_elem[8];

endmodule
`default_nettype wire

/* sv/aarm_norm.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aarm_norm: axis normalization pipeline
// Magnitude alignment, sum of squares, bit-per-stage square root and
// bit-per-stage restoring division to a Q2.30 unit vector.
// ----------------------------------------------------------------------------
module aarm_norm import aarm_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic signed [31:0] i_axis_x,
    input  wire logic signed [31:0] i_axis_y,
    input  wire logic signed [31:0] i_axis_z,
    output t_unit                   o_unit
);

    typedef struct packed {
        logic [2:0][31:0] mag;
        logic [2:0]       neg;
        logic             zero;
        logic [63:0]      rem;
        logic [63:0]      res;
    } t_sq;

    typedef struct packed {
        logic [2:0][63:0] rem;
        logic [2:0][30:0] quo;
        logic [31:0]      dvs;
        logic [2:0]       neg;
        logic             zero;
    } t_dv;

    logic [2:0][31:0] r1_mag, n1_mag;
    logic [2:0]       r1_neg, n1_neg;
    logic [31:0]      r1_mx, n1_mx;
    logic [2:0][31:0] r2_mag, n2_mag;
    logic [2:0]       r2_neg;
    logic             r2_zero;
    logic [2:0][63:0] r3_sqr;
    logic [2:0][31:0] r3_mag;
    logic [2:0]       r3_neg;
    logic             r3_zero;
    t_sq              r4, n4;
    t_sq              r_sq [32];
    t_sq              n_sq [32];
    t_dv              r_dv [31];
    t_dv              n_dv [31];
    logic [4:0]       pos;
    logic [4:0]       sh;

    // stage 1: magnitudes
    always_comb begin
        logic signed [31:0] a [3];
        a[0] = i_axis_x;
        a[1] = i_axis_y;
        a[2] = i_axis_z;
        for (int l = 0; l < 3; l++) begin
            n1_neg[l] = a[l][31];
            n1_mag[l] = a[l][31] ? (~a[l] + 32'd1) : a[l];
        end
        n1_mx = n1_mag[0];
        if (n1_mag[1] > n1_mx) n1_mx = n1_mag[1];
        if (n1_mag[2] > n1_mx) n1_mx = n1_mag[2];
    end

    // stage 2: align largest to bit 30 or above
    always_comb begin
        pos = 5'd0;
        for (int b = 0; b < 32; b++) begin
            if (r1_mx[b]) pos = 5'(b);
        end
        sh = (pos >= 5'd30) ? 5'd0 : 5'd30 - pos;
        for (int l = 0; l < 3; l++) begin
            n2_mag[l] = r1_mag[l] << sh;
        end
    end

    // stage 4: sum of squares
    always_comb begin
        n4      = '0;
        n4.mag  = r3_mag;
        n4.neg  = r3_neg;
        n4.zero = r3_zero;
        n4.rem  = r3_sqr[0] + r3_sqr[1] + r3_sqr[2];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_mag  <= n1_mag;
            r1_neg  <= n1_neg;
            r1_mx   <= n1_mx;
            r2_mag  <= n2_mag;
            r2_neg  <= r1_neg;
            r2_zero <= (r1_mx == 32'd0);
            for (int l = 0; l < 3; l++) begin
                r3_sqr[l] <= 64'(r2_mag[l]) * 64'(r2_mag[l]);
            end
            r3_mag  <= r2_mag;
            r3_neg  <= r2_neg;
            r3_zero <= r2_zero;
            r4      <= n4;
        end
    end

    // square root, one result bit per stage
    for (genvar g = 0; g < 32; g++) begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (2 * (31 - g));
        t_sq         prev;
        logic [63:0] trial;
        if (g == 0) begin : g_first
            assign prev = r4;
        end else begin : g_next
            assign prev = r_sq[g-1];
        end
        always_comb begin
            trial    = prev.res + BIT;
            n_sq[g]  = prev;
            if (prev.rem >= trial) begin
                n_sq[g].rem = prev.rem - trial;
                n_sq[g].res = (prev.res >> 1) + BIT;
            end else begin
                n_sq[g].res = prev.res >> 1;
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sq[g] <= n_sq[g];
            end
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar g = 0; g < 31; g++) begin : g_div
        t_dv              prev;
        logic [63:0]      sub;
        if (g == 0) begin : g_first
            always_comb begin
                prev      = '0;
                prev.dvs  = r_sq[31].res[31:0];
                prev.neg  = r_sq[31].neg;
                prev.zero = r_sq[31].zero;
                for (int l = 0; l < 3; l++) begin
                    prev.rem[l] = (64'(r_sq[31].mag[l]) << 30) + (r_sq[31].res >> 1);
                end
            end
        end else begin : g_next
            assign prev = r_dv[g-1];
        end
        always_comb begin
            sub     = 64'(prev.dvs) << (30 - g);
            n_dv[g] = prev;
            for (int l = 0; l < 3; l++) begin
                if (prev.rem[l] >= sub) begin
                    n_dv[g].rem[l]          = prev.rem[l] - sub;
                    n_dv[g].quo[l][30 - g]  = 1'b1;
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv[g] <= n_dv[g];
            end
        end
    end

    always_comb begin
        logic [30:0]        q;
        logic signed [31:0] u [3];
        for (int l = 0; l < 3; l++) begin
            q = r_dv[30].quo[l];
            if (q > Q30_ONE) q = Q30_ONE;
            u[l] = r_dv[30].neg[l] ? -$signed({1'b0, q}) : $signed({1'b0, q});
            if (r_dv[30].zero) u[l] = '0;
        end
        o_unit.u_x  = u[0];
        o_unit.u_y  = u[1];
        o_unit.u_z  = u[2];
        o_unit.zero = r_dv[30].zero;
    end

endmodule
`default_nettype wire

/* sv/aarm_sincos.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aarm_sincos: angle reduction and sine/cosine pipeline
// Modulo two pi by compare-subtract stages, quadrant split, and a nine-step
// Horner Taylor series with constant-reciprocal division per step.
// ----------------------------------------------------------------------------
module aarm_sincos import aarm_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic signed [31:0] i_angle,
    output t_trig                   o_trig
);

    typedef struct packed {
        logic [30:0] x;
        logic [31:0] x2;
        logic [1:0]  quad;
        logic [30:0] hs;
        logic [30:0] hc;
        logic [31:0] ps;
        logic [31:0] pc;
    } t_hst;

    localparam logic [1:0]  QUAD_0 = 2'd0;
    localparam logic [1:0]  QUAD_1 = 2'd1;
    localparam logic [1:0]  QUAD_2 = 2'd2;
    localparam logic [1:0]  QUAD_3 = 2'd3;
    localparam logic [63:0] OFS    = TWO_PI_Q44 << 13;
    localparam logic [46:0] QTR    = 47'(TWO_PI_Q44 >> 2);

    logic [60:0] r_t, n_t;
    logic [60:0] r_red [15];
    logic [60:0] n_red [15];
    logic [30:0] r_qx, n_qx;
    logic [1:0]  r_qq, n_qq;
    t_hst        r_x2, n_x2;
    t_hst        r_hm [9];
    t_hst        n_hm [9];
    t_hst        r_hd [9];
    t_hst        n_hd [9];
    logic [30:0] r_s0, n_s0;
    logic [30:0] r_c0;
    logic [1:0]  r_sq;
    t_trig       r_trig, n_trig;

    always_comb begin
        logic [63:0] t;
        t   = ({{32{i_angle[31]}}, i_angle} << 28) + OFS;
        n_t = t[60:0];
    end

    for (genvar g = 0; g < 15; g++) begin : g_red
        localparam logic [60:0] PS = 61'(TWO_PI_Q44 << (14 - g));
        logic [60:0] prev;
        if (g == 0) begin : g_first
            assign prev = r_t;
        end else begin : g_next
            assign prev = r_red[g-1];
        end
        assign n_red[g] = (prev >= PS) ? prev - PS : prev;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_red[g] <= n_red[g];
            end
        end
    end

    always_comb begin
        logic [46:0] red;
        logic [46:0] off;
        logic [46:0] rest;
        red = r_red[14][46:0];
        if (red >= 47'(3) * QTR) begin
            n_qq = QUAD_3;
            off  = 47'(3) * QTR;
        end else if (red >= 47'(2) * QTR) begin
            n_qq = QUAD_2;
            off  = 47'(2) * QTR;
        end else if (red >= QTR) begin
            n_qq = QUAD_1;
            off  = QTR;
        end else begin
            n_qq = QUAD_0;
            off  = '0;
        end
        rest = red - off;
        n_qx = rest[44:14];
    end

    always_comb begin
        logic [61:0] p;
        p       = 62'(r_qx) * 62'(r_qx);
        n_x2    = '0;
        n_x2.x  = r_qx;
        n_x2.quad = r_qq;
        n_x2.x2 = p[61:30];
        n_x2.hs = Q30_ONE;
        n_x2.hc = Q30_ONE;
    end

    for (genvar g = 0; g < 9; g++) begin : g_horner
        localparam int unsigned DS = SIN_DIV[g];
        localparam int unsigned DC = COS_DIV[g];
        localparam int unsigned LS = $clog2(DS);
        localparam int unsigned LC = $clog2(DC);
        localparam logic [33:0] MS =
            34'(((66'd1 << (32 + LS)) + 66'(DS) - 66'd1) / 66'(DS));
        localparam logic [33:0] MC =
            34'(((66'd1 << (32 + LC)) + 66'(DC) - 66'd1) / 66'(DC));
        t_hst        prev;
        logic [62:0] mps, mpc;
        logic [65:0] dqs, dqc;
        if (g == 0) begin : g_first
            assign prev = r_x2;
        end else begin : g_next
            assign prev = r_hd[g-1];
        end
        always_comb begin
            mps      = 63'(prev.x2) * 63'(prev.hs);
            mpc      = 63'(prev.x2) * 63'(prev.hc);
            n_hm[g]    = prev;
            n_hm[g].ps = mps[61:30];
            n_hm[g].pc = mpc[61:30];
        end
        always_comb begin
            dqs        = (66'(r_hm[g].ps) * 66'(MS)) >> (32 + LS);
            dqc        = (66'(r_hm[g].pc) * 66'(MC)) >> (32 + LC);
            n_hd[g]    = r_hm[g];
            n_hd[g].hs = Q30_ONE - dqs[30:0];
            n_hd[g].hc = Q30_ONE - dqc[30:0];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_hm[g] <= n_hm[g];
                r_hd[g] <= n_hd[g];
            end
        end
    end

    always_comb begin
        logic [61:0] p;
        p    = 62'(r_hd[8].x) * 62'(r_hd[8].hs);
        n_s0 = (p[61:30] > 32'(Q30_ONE)) ? Q30_ONE : p[60:30];
    end

    always_comb begin
        logic signed [31:0] s;
        logic signed [31:0] c;
        s = $signed({1'b0, r_s0});
        c = $signed({1'b0, r_c0});
        case (r_sq)
            QUAD_0:  begin n_trig.sn = s;  n_trig.cs = c;  end
            QUAD_1:  begin n_trig.sn = c;  n_trig.cs = -s; end
            QUAD_2:  begin n_trig.sn = -s; n_trig.cs = -c; end
            default: begin n_trig.sn = -c; n_trig.cs = s;  end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t    <= n_t;
            r_qx   <= n_qx;
            r_qq   <= n_qq;
            r_x2   <= n_x2;
            r_s0   <= n_s0;
            r_c0   <= r_hd[8].hc;
            r_sq   <= r_hd[8].quad;
            r_trig <= n_trig;
        end
    end

    assign o_trig = r_trig;

endmodule
`default_nettype wire

/* sv/aarm_matrix.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aarm_matrix: Rodrigues matrix assembly
// Axis products, scaling by one minus cosine, element sums and rounding
// to the output format with clamping.
// ----------------------------------------------------------------------------
module aarm_matrix import aarm_pkg::*; #(
    parameter int unsigned OUT_FRAC_BITS = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_en,
    input  wire t_unit                           i_unit,
    input  wire t_trig                           i_trig,
    output logic signed [OUT_FRAC_BITS+1:0]      o_elem [9],
    output logic                                 o_zero
);

    localparam int unsigned OUT_W = OUT_FRAC_BITS + 2;
    localparam int unsigned SH    = 30 - OUT_FRAC_BITS;
    localparam logic [35:0] HALF  = (36'd1 << SH) >> 1;
    localparam logic [35:0] LIM   = 36'd1 << OUT_FRAC_BITS;

    function automatic logic signed [33:0] mulq(input logic signed [33:0] a,
                                                 input logic signed [33:0] b);
        logic        neg;
        logic [33:0] ma;
        logic [33:0] mb;
        logic [67:0] p;
        logic [33:0] m;
        neg = a[33] ^ b[33];
        ma  = a[33] ? 34'(-a) : 34'(a);
        mb  = b[33] ? 34'(-b) : 34'(b);
        p   = (68'(ma) * 68'(mb) + (68'd1 << 29)) >> 30;
        m   = p[33:0];
        return neg ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic [OUT_W-1:0] to_out(input logic signed [35:0] v);
        logic [35:0] m;
        logic [35:0] r;
        m = v[35] ? 36'(-v) : 36'(v);
        m = (m + HALF) >> SH;
        if (m > LIM) m = LIM;
        r = v[35] ? -m : m;
        return r[OUT_W-1:0];
    endfunction

    // product order: xx yy zz xy xz yz
    logic signed [33:0] r1_p [6];
    logic signed [33:0] r1_s [3];
    logic signed [33:0] r1_omc;
    logic signed [33:0] r1_cs;
    logic               r1_zero;
    logic signed [33:0] r2_d [6];
    logic signed [33:0] r2_s [3];
    logic signed [33:0] r2_cs;
    logic               r2_zero;
    logic [OUT_W-1:0]   r3_el [9];
    logic               r3_zero;
    logic signed [33:0] ux, uy, uz, sn;

    assign ux = 34'(i_unit.u_x);
    assign uy = 34'(i_unit.u_y);
    assign uz = 34'(i_unit.u_z);
    assign sn = 34'(i_trig.sn);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_p[0] <= mulq(ux, ux);
            r1_p[1] <= mulq(uy, uy);
            r1_p[2] <= mulq(uz, uz);
            r1_p[3] <= mulq(ux, uy);
            r1_p[4] <= mulq(ux, uz);
            r1_p[5] <= mulq(uy, uz);
            r1_s[0] <= mulq(ux, sn);
            r1_s[1] <= mulq(uy, sn);
            r1_s[2] <= mulq(uz, sn);
            r1_omc  <= 34'(Q30_ONE) - 34'(i_trig.cs);
            r1_cs   <= 34'(i_trig.cs);
            r1_zero <= i_unit.zero;
            for (int i = 0; i < 6; i++) begin
                r2_d[i] <= mulq(r1_p[i], r1_omc);
            end
            r2_s    <= r1_s;
            r2_cs   <= r1_cs;
            r2_zero <= r1_zero;
            r3_el[0] <= to_out(36'(r2_cs) + 36'(r2_d[0]));
            r3_el[1] <= to_out(36'(r2_d[3]) - 36'(r2_s[2]));
            r3_el[2] <= to_out(36'(r2_d[4]) + 36'(r2_s[1]));
            r3_el[3] <= to_out(36'(r2_d[3]) + 36'(r2_s[2]));
            r3_el[4] <= to_out(36'(r2_cs) + 36'(r2_d[1]));
            r3_el[5] <= to_out(36'(r2_d[5]) - 36'(r2_s[0]));
            r3_el[6] <= to_out(36'(r2_d[4]) - 36'(r2_s[1]));
            r3_el[7] <= to_out(36'(r2_d[5]) + 36'(r2_s[0]));
            r3_el[8] <= to_out(36'(r2_cs) + 36'(r2_d[2]));
            r3_zero  <= r2_zero;
        end
    end

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            o_elem[i] = $signed(r3_el[i]);
        end
    end
    assign o_zero = r3_zero;

endmodule
`default_nettype wire

/* sv/aarm_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aarm_checker: port-level checks for axis_angle_rotation_matrix
// Stall coupling, output hold, range and zero-axis form of the result beat.
// ----------------------------------------------------------------------------
module aarm_checker #(
    parameter int unsigned OUT_FRAC_BITS = 16
) (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_in_valid,
    input wire logic                            o_in_stall,
    input wire logic                            o_out_valid,
    input wire logic                            i_out_stall,
    input wire logic signed [OUT_FRAC_BITS+1:0] o_elem_r0c0,
    input wire logic signed [OUT_FRAC_BITS+1:0] o_elem_r0c1,
    input wire logic signed [OUT_FRAC_BITS+1:0] o_elem_r0c2,
    input wire logic signed [OUT_FRAC_BITS+1:0] o_elem_r1c0,
    input wire logic signed [OUT_FRAC_BITS+1:0] o_elem_r1c1,
    input wire logic signed [OUT_FRAC_BITS+1:0] o_elem_r1c2,
    input wire logic signed [OUT_FRAC_BITS+1:0] o_elem_r2c0,
    input wire logic signed [OUT_FRAC_BITS+1:0] o_elem_r2c1,
    input wire logic signed [OUT_FRAC_BITS+1:0] o_elem_r2c2,
    input wire logic                            o_zero_axis
);

    localparam int unsigned OUT_W = OUT_FRAC_BITS + 2;
    localparam logic signed [OUT_FRAC_BITS+1:0] HI = OUT_W'(1) << OUT_FRAC_BITS;
    localparam logic signed [OUT_FRAC_BITS+1:0] LO = -HI;

    logic in_rng;
    logic unused_in;

    assign unused_in = i_in_valid;

    always_comb begin
        logic signed [OUT_FRAC_BITS+1:0] e [9];
        e[0] = o_elem_r0c0; e[1] = o_elem_r0c1; e[2] = o_elem_r0c2;
        e[3] = o_elem_r1c0; e[4] = o_elem_r1c1; e[5] = o_elem_r1c2;
        e[6] = o_elem_r2c0; e[7] = o_elem_r2c1; e[8] = o_elem_r2c2;
        in_rng = 1'b1;
        for (int i = 0; i < 9; i++) begin
            if (e[i] > HI || e[i] < LO) in_rng = 1'b0;
        end
    end

    a_stall_coupling: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        unused_in || !unused_in |-> (o_in_stall == (o_out_valid && i_out_stall)))
        else $error("input stall does not follow held output beat");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_elem_r0c0)
            && $stable(o_elem_r1c1) && $stable(o_zero_axis))
        else $error("stalled output beat changed");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> in_rng)
        else $error("matrix element beyond unit range");

    a_zero_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_zero_axis |-> o_elem_r0c1 == 0 && o_elem_r0c2 == 0
            && o_elem_r1c0 == 0 && o_elem_r1c2 == 0 && o_elem_r2c0 == 0
            && o_elem_r2c1 == 0 && o_elem_r0c0 == o_elem_r1c1
            && o_elem_r1c1 == o_elem_r2c2)
        else $error("zero axis beat is not a scaled identity");

endmodule

bind axis_angle_rotation_matrix aarm_checker #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
) u_aarm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_elem_r0c0 (o_elem_r0c0),
    .o_elem_r0c1 (o_elem_r0c1),
    .o_elem_r0c2 (o_elem_r0c2),
    .o_elem_r1c0 (o_elem_r1c0),
    .o_elem_r1c1 (o_elem_r1c1),
    .o_elem_r1c2 (o_elem_r1c2),
    .o_elem_r2c0 (o_elem_r2c0),
    .o_elem_r2c1 (o_elem_r2c1),
    .o_elem_r2c2 (o_elem_r2c2),
    .o_zero_axis (o_zero_axis)
);
`default_nettype wire
